// File: rtl/gnms_pkg.sv
// Shared types and constants for the gradient non-maximum suppression unit.
package gnms_pkg;

    localparam int MAG_W   = 16;
    localparam int PHASE_W = 15;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 12;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Depth of the job queue between the front and back ends.
    localparam int QDEPTH = 4;

    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic signed [PHASE_W-1:0] phase_t;

    // Quantized gradient direction. The two diagonals are named after the
    // neighbour on the right: one row down or one row up.
    typedef enum logic [1:0] {
        DIR_HORZ,
        DIR_VERT,
        DIR_DIAG_DOWN,
        DIR_DIAG_UP
    } dir_t;

    // Magnitudes of one window column: row above, centre row, row below.
    typedef struct packed {
        mag_t top;
        mag_t mid;
        mag_t bot;
    } mags_t;

    typedef struct packed {
        mags_t  mag;
        phase_t phase_mid;
        phase_t phase_bot;
        dir_t   dir_mid;
        dir_t   dir_bot;
    } col_t;

    // One job: the window around column col-1 of row row-1 (and row row on
    // the last row), with flags saying which results it yields.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             has_right;
        logic             last_row;
        mags_t            left;
        col_t             centre;
        col_t             right;
    } job_t;

endpackage

// File: rtl/gnms_front.sv
// Front end: input handshake, raster counters, line buffer and window build.
module gnms_front
    import gnms_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mag_t                 s_magnitude,
    input  phase_t               s_phase,
    output logic                 q_push,
    output job_t                 q_job,
    input  logic                 q_full
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WCAP = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;

    localparam phase_t TH_PI8      = 15'sd1608;
    localparam phase_t TH_3PI8     = 15'sd4825;
    localparam phase_t TH_5PI8     = 15'sd8042;
    localparam phase_t TH_7PI8     = 15'sd11259;
    localparam phase_t TH_PI8_NEG  = -15'sd1608;
    localparam phase_t TH_3PI8_NEG = -15'sd4825;
    localparam phase_t TH_5PI8_NEG = -15'sd8042;
    localparam phase_t TH_7PI8_NEG = -15'sd11259;

    typedef struct packed {
        mag_t   mag_prev;
        phase_t phase_prev;
        mag_t   mag_older;
    } lb_word_t;

    function automatic dir_t classify(phase_t p);
        logic dy_pos;
        logic dy_neg;
        logic dx_pos;
        logic dx_neg;
        dir_t d;
        dy_pos = (p > TH_PI8) && (p < TH_7PI8);
        dy_neg = (p < TH_PI8_NEG) && (p > TH_7PI8_NEG);
        dx_pos = (p > TH_3PI8_NEG) && (p < TH_3PI8);
        dx_neg = !dx_pos && ((p > TH_5PI8) || (p < TH_5PI8_NEG));
        priority if (!dy_pos && !dy_neg) begin
            d = DIR_HORZ;
        end else if (!dx_pos && !dx_neg) begin
            d = DIR_VERT;
        end else if (dx_pos == dy_pos) begin
            d = DIR_DIAG_DOWN;
        end else begin
            d = DIR_DIAG_UP;
        end
        return d;
    endfunction

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic [12:0]      width_last13;
    logic [AW-1:0]    col_last;
    logic [ROW_W-1:0] row_last;

    logic [AW-1:0]    col_cnt_reg;
    logic [ROW_W-1:0] row_cnt_reg;
    logic [AW-1:0]    col_cnt_next;
    logic [ROW_W-1:0] row_cnt_next;

    logic             a_valid_reg;
    mag_t             a_mag_reg;
    phase_t           a_phase_reg;
    logic [AW-1:0]    a_col_reg;
    logic [ROW_W-1:0] a_row_reg;
    logic             a_col_zero_reg;
    logic             a_col_one_reg;
    logic             a_row_zero_reg;
    logic             a_row_one_reg;
    logic             a_end_col_reg;
    logic             a_last_row_reg;

    lb_word_t         lb_mem [MAX_WIDTH];
    lb_word_t         rd_reg;
    lb_word_t         wr_word;

    col_t             p1_reg;
    mags_t            p2_reg;
    col_t             new_col;

    logic             need_push;
    logic             a_fire;
    logic             s_fire;

    // Effective frame size, saturated into the supported range.
    always_comb begin
        if (image_width_reg < 12'd2) begin
            width_last13 = 13'd1;
        end else if ({1'b0, image_width_reg} > 13'(WCAP)) begin
            width_last13 = 13'(WCAP - 1);
        end else begin
            width_last13 = {1'b0, image_width_reg} - 13'd1;
        end
    end

    assign col_last = width_last13[AW-1:0];
    assign row_last = (image_height_reg < 12'd2) ? 12'd1 : image_height_reg - 12'd1;

    assign need_push = a_valid_reg && !a_col_zero_reg && !a_row_zero_reg;
    assign a_fire    = a_valid_reg && (!need_push || !q_full);
    assign s_ready   = !a_valid_reg || a_fire;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        if (col_cnt_reg == col_last) begin
            col_cnt_next = '0;
            row_cnt_next = (row_cnt_reg == row_last) ? '0 : row_cnt_reg + 12'd1;
        end else begin
            col_cnt_next = col_cnt_reg + 1'b1;
            row_cnt_next = row_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= 12'd640;
            image_height_reg <= 12'd480;
            col_cnt_reg      <= '0;
            row_cnt_reg      <= '0;
            a_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_IMAGE_WIDTH) begin
                    image_width_reg <= cfg_wr_data;
                end else if (cfg_index == REG_IMAGE_HEIGHT) begin
                    image_height_reg <= cfg_wr_data;
                end
                col_cnt_reg <= '0;
                row_cnt_reg <= '0;
            end else if (s_fire) begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            if (s_fire) begin
                a_valid_reg <= 1'b1;
            end else if (a_fire) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_mag_reg      <= s_magnitude;
            a_phase_reg    <= s_phase;
            a_col_reg      <= col_cnt_reg;
            a_row_reg      <= row_cnt_reg;
            a_col_zero_reg <= (col_cnt_reg == '0);
            a_col_one_reg  <= (col_cnt_reg == AW'(1));
            a_row_zero_reg <= (row_cnt_reg == '0);
            a_row_one_reg  <= (row_cnt_reg == 12'd1);
            a_end_col_reg  <= (col_cnt_reg == col_last);
            a_last_row_reg <= (row_cnt_reg == row_last);
        end
    end

    // Line buffer: each entry holds the two rows above the incoming pixel.
    assign wr_word = '{mag_prev: a_mag_reg, phase_prev: a_phase_reg,
                       mag_older: rd_reg.mag_prev};

    always_ff @(posedge aclk) begin
        if (a_fire) begin
            lb_mem[a_col_reg] <= wr_word;
        end
        if (s_fire) begin
            rd_reg <= lb_mem[col_cnt_reg];
        end
    end

    // On the second row the row above the centre is clamped to the centre.
    always_comb begin
        new_col.mag.top   = a_row_one_reg ? rd_reg.mag_prev : rd_reg.mag_older;
        new_col.mag.mid   = rd_reg.mag_prev;
        new_col.mag.bot   = a_mag_reg;
        new_col.phase_mid = rd_reg.phase_prev;
        new_col.phase_bot = a_phase_reg;
        new_col.dir_mid   = classify(rd_reg.phase_prev);
        new_col.dir_bot   = classify(a_phase_reg);
    end

    always_ff @(posedge aclk) begin
        if (a_fire) begin
            p1_reg <= new_col;
            p2_reg <= p1_reg.mag;
        end
    end

    always_comb begin
        q_job.col       = COL_W'(a_col_reg);
        q_job.row       = a_row_reg;
        q_job.has_right = a_end_col_reg;
        q_job.last_row  = a_last_row_reg;
        q_job.left      = a_col_one_reg ? p1_reg.mag : p2_reg;
        q_job.centre    = p1_reg;
        q_job.right     = new_col;
    end

    assign q_push = need_push && !q_full;

endmodule

// File: rtl/gnms_queue.sv
// Small job queue that decouples the front end from the back end.
module gnms_queue
    import gnms_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head_job,
    output logic empty
);

    localparam int PW = $clog2(QDEPTH);

    job_t          q_mem [QDEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == (PW + 1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/gnms_back.sv
// Back end: walks each job's results, suppresses non-maxima, drives the output.
module gnms_back
    import gnms_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  job_t             job,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [COL_W-1:0] m_column,
    output logic [ROW_W-1:0] m_row,
    output mag_t             m_kept_magnitude,
    output phase_t           m_phase_out,
    output logic             m_last
);

    // Bit 1 picks the right-hand centre column, bit 0 the bottom centre row.
    localparam logic [1:0] SUB_M_MID = 2'b00;
    localparam logic [1:0] SUB_M_BOT = 2'b01;
    localparam logic [1:0] SUB_R_MID = 2'b10;
    localparam logic [1:0] SUB_R_BOT = 2'b11;

    logic [1:0]       sub_reg;
    logic [1:0]       sub_next;
    logic             sub_done;
    logic             sel_right;
    logic             sel_bot;
    logic             out_free;
    logic             emit;

    mags_t            lcol;
    mags_t            ccol;
    mags_t            rcol;
    mag_t             nb [3][3];
    col_t             cc;
    phase_t           ctr_phase;
    dir_t             ctr_dir;
    mag_t             ctr_mag;
    mag_t             nb_a;
    mag_t             nb_b;
    mag_t             kept;

    logic             m_valid_reg;
    logic [COL_W-1:0] m_column_reg;
    logic [ROW_W-1:0] m_row_reg;
    mag_t             m_kept_magnitude_reg;
    phase_t           m_phase_out_reg;
    logic             m_last_reg;

    assign sel_right = sub_reg[1];
    assign sel_bot   = sub_reg[0];

    always_comb begin
        sub_next = SUB_M_MID;
        sub_done = 1'b1;
        unique case (sub_reg)
            SUB_M_MID: begin
                if (job.last_row) begin
                    sub_next = SUB_M_BOT;
                    sub_done = 1'b0;
                end else if (job.has_right) begin
                    sub_next = SUB_R_MID;
                    sub_done = 1'b0;
                end
            end
            SUB_M_BOT: begin
                if (job.has_right) begin
                    sub_next = SUB_R_MID;
                    sub_done = 1'b0;
                end
            end
            SUB_R_MID: begin
                if (job.last_row) begin
                    sub_next = SUB_R_BOT;
                    sub_done = 1'b0;
                end
            end
            SUB_R_BOT: begin
                sub_done = 1'b1;
            end
        endcase
    end

    // 3x3 neighbourhood of the current centre, clamped at the right edge
    // and below the last row.
    always_comb begin
        lcol = sel_right ? job.centre.mag : job.left;
        ccol = sel_right ? job.right.mag : job.centre.mag;
        rcol = job.right.mag;
        nb[0][0] = sel_bot ? lcol.mid : lcol.top;
        nb[1][0] = sel_bot ? lcol.bot : lcol.mid;
        nb[2][0] = lcol.bot;
        nb[0][1] = sel_bot ? ccol.mid : ccol.top;
        nb[1][1] = sel_bot ? ccol.bot : ccol.mid;
        nb[2][1] = ccol.bot;
        nb[0][2] = sel_bot ? rcol.mid : rcol.top;
        nb[1][2] = sel_bot ? rcol.bot : rcol.mid;
        nb[2][2] = rcol.bot;
    end

    always_comb begin
        cc        = sel_right ? job.right : job.centre;
        ctr_phase = sel_bot ? cc.phase_bot : cc.phase_mid;
        ctr_dir   = sel_bot ? cc.dir_bot : cc.dir_mid;
        ctr_mag   = nb[1][1];
        unique case (ctr_dir)
            DIR_HORZ: begin
                nb_a = nb[1][2];
                nb_b = nb[1][0];
            end
            DIR_VERT: begin
                nb_a = nb[2][1];
                nb_b = nb[0][1];
            end
            DIR_DIAG_DOWN: begin
                nb_a = nb[2][2];
                nb_b = nb[0][0];
            end
            DIR_DIAG_UP: begin
                nb_a = nb[0][2];
                nb_b = nb[2][0];
            end
        endcase
        kept = ((nb_a > ctr_mag) || (nb_b > ctr_mag)) ? '0 : ctr_mag;
    end

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = !q_empty && out_free;
    assign q_pop    = emit && sub_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg     <= SUB_M_MID;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                sub_reg     <= sub_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_column_reg         <= sel_right ? job.col : job.col - 11'd1;
            m_row_reg            <= sel_bot ? job.row : job.row - 12'd1;
            m_kept_magnitude_reg <= kept;
            m_phase_out_reg      <= ctr_phase;
            m_last_reg           <= sub_done;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_column         = m_column_reg;
    assign m_row            = m_row_reg;
    assign m_kept_magnitude = m_kept_magnitude_reg;
    assign m_phase_out      = m_phase_out_reg;
    assign m_last           = m_last_reg;

endmodule

// File: rtl/gradient_non_max_suppression_unit.sv
// Top level of the gradient non-maximum suppression unit.
// Path: input register in the front end, job queue, then the back end's output register.
// Throughput: one input item per cycle while each item yields at most one result; the back
// end emits one result per cycle while m_ready is high, so row ends and the last row (two
// to four results per item) slow intake to the result rate once the four-entry job queue fills.
// Reset: synchronous, active low; counters and handshakes clear, the line buffer does not.
module gradient_non_max_suppression_unit
    import gnms_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration write port: index 0 is the image width, index 1 the height.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,

    // Gradient pixels in raster order.
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [MAG_W-1:0]     s_magnitude,
    input  logic signed [PHASE_W-1:0] s_phase,

    // Suppressed pixels with their coordinates.
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COL_W-1:0]     m_column,
    output logic [ROW_W-1:0]     m_row,
    output logic [MAG_W-1:0]     m_kept_magnitude,
    output logic signed [PHASE_W-1:0] m_phase_out,
    output logic                 m_last
);

    // The front end keeps the raster position, reads the line buffer for the
    // two rows above the incoming pixel and assembles a 3x3 window. Every
    // item from the second row and second column on becomes one job in the
    // queue; the job's flags say whether it also releases the right-hand
    // edge pixel and whether the bottom row is to be emitted as well.
    logic  q_push;
    job_t  q_push_job;
    logic  q_full;
    logic  q_pop;
    job_t  q_head_job;
    logic  q_empty;

    gnms_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_magnitude (s_magnitude),
        .s_phase     (s_phase),
        .q_push      (q_push),
        .q_job       (q_push_job),
        .q_full      (q_full)
    );

    // The queue lets the front end keep taking items while the back end
    // works through a job that yields several results.
    gnms_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (q_head_job),
        .empty    (q_empty)
    );

    // While the output is not stalled, the back end emits one result per cycle
    // into a registered output stage, comparing each centre against its two
    // neighbours along the quantized gradient direction.
    gnms_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .job              (q_head_job),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_column         (m_column),
        .m_row            (m_row),
        .m_kept_magnitude (m_kept_magnitude),
        .m_phase_out      (m_phase_out),
        .m_last           (m_last)
    );

endmodule

// File: sim/gradient_non_max_suppression_unit_test.sv
// Self-checking testbench for the gradient non-maximum suppression unit.
module gradient_non_max_suppression_unit_test;
    import gnms_pkg::*;

    // Frame limits and register reset values of the unit.
    localparam int MAX_W   = 2048;
    localparam int MAX_H   = 4095;
    localparam int RESET_W = 640;
    localparam int RESET_H = 480;

    // Direction boundaries in Q3.12 radians: pi/8, 3pi/8, 5pi/8 and 7pi/8.
    localparam int PI_8  = 1608;
    localparam int PI3_8 = 4825;
    localparam int PI5_8 = 8042;
    localparam int PI7_8 = 11259;
    // Largest phase in normal use, pi in Q3.12.
    localparam int PHASE_SPAN = 12868;

    // Quiet cycles before a register write and at the end of the run.
    localparam int HOLD_OFF      = 16;
    localparam int RANDOM_PIXELS = 110;
    localparam int DRAIN_LIMIT   = 4000;

    // One thinned pixel as the unit should report it.
    typedef struct {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        mag_t             kept;
        phase_t           phase;
        logic             last;
    } thinned_t;

    // Tracks the frame position and the last three rows, predicts the thinned
    // pixels that each taken item releases and checks the unit's results
    // against them in order.
    class thinned_pixel_board;
        mag_t             mag_lines[3][MAX_W];
        phase_t           phase_lines[3][MAX_W];
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        int unsigned      col_pos;
        int unsigned      row_pos;
        int unsigned      fill_slot;
        thinned_t         due[$];
        int unsigned      pixels_seen;
        int unsigned      results_seen;
        int unsigned      mismatches;

        function new();
            width_reg    = RESET_W;
            height_reg   = RESET_H;
            col_pos      = 0;
            row_pos      = 0;
            fill_slot    = 0;
            pixels_seen  = 0;
            results_seen = 0;
            mismatches   = 0;
        endfunction

        function int unsigned pending();
            return due.size();
        endfunction

        // Any write restarts the frame; the line stores keep their contents.
        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            if (index == REG_IMAGE_WIDTH) begin
                width_reg = data;
            end else if (index == REG_IMAGE_HEIGHT) begin
                height_reg = data;
            end else begin
                return;
            end
            col_pos = 0;
            row_pos = 0;
        endfunction

        // Line slot holding row y while row r is being received.
        function int unsigned slot_of(int unsigned r, int unsigned y);
            return (fill_slot + 3 - (r - y) % 3) % 3;
        endfunction

        // Neighbour magnitude with its coordinates clamped to the image and to
        // the three rows held.
        function mag_t mag_near(int unsigned r, int x, int y, int unsigned w, int unsigned h);
            int unsigned cx;
            int unsigned cy;
            cx = (x < 0) ? 0 : (x > int'(w) - 1) ? w - 1 : x;
            cy = (y < 0) ? 0 : (y > int'(h) - 1) ? h - 1 : y;
            if (cy > r) cy = r;
            if (cy + 2 < r) cy = r - 2;
            return mag_lines[slot_of(r, cy)][cx];
        endfunction

        // Queue the thinned pixel at (x, y) while row r is current.
        function void thin_pixel(int unsigned r, int unsigned x, int unsigned y,
                                 int unsigned w, int unsigned h);
            int unsigned s;
            mag_t        centre;
            mag_t        ahead;
            mag_t        behind;
            phase_t      p;
            int          dx;
            int          dy;
            thinned_t    e;
            s      = slot_of(r, y);
            centre = mag_lines[s][x];
            p      = phase_lines[s][x];
            dx     = 0;
            dy     = 0;
            if (p > PI_8 && p < PI7_8) dy = 1;
            else if (p < -PI_8 && p > -PI7_8) dy = -1;
            if (p > -PI3_8 && p < PI3_8) dx = 1;
            else if (p > PI5_8 || p < -PI5_8) dx = -1;
            ahead  = mag_near(r, int'(x) + dx, int'(y) + dy, w, h);
            behind = mag_near(r, int'(x) - dx, int'(y) - dy, w, h);
            e.column = x[COL_W-1:0];
            e.row    = y[ROW_W-1:0];
            e.kept   = (ahead > centre || behind > centre) ? '0 : centre;
            e.phase  = p;
            e.last   = 1'b0;
            due.push_back(e);
        endfunction

        // Store a taken pixel and queue everything it releases.
        function void note_pixel(mag_t mag, phase_t phase);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            int unsigned before_count;
            thinned_t    e;
            w = width_reg;
            if (w < 2) w = 2;
            if (w > MAX_W) w = MAX_W;
            h = height_reg;
            if (h < 2) h = 2;
            if (h > MAX_H) h = MAX_H;
            c = (col_pos >= w) ? w - 1 : col_pos;
            r = (row_pos >= h) ? h - 1 : row_pos;
            mag_lines[fill_slot][c]   = mag;
            phase_lines[fill_slot][c] = phase;
            before_count = due.size();
            if (r >= 1 && c >= 1) begin
                thin_pixel(r, c - 1, r - 1, w, h);
                if (r == h - 1) thin_pixel(r, c - 1, r, w, h);
            end
            if (r >= 1 && c == w - 1) begin
                thin_pixel(r, c, r - 1, w, h);
                if (r == h - 1) thin_pixel(r, c, r, w, h);
            end
            if (due.size() > before_count) begin
                e = due.pop_back();
                e.last = 1'b1;
                due.push_back(e);
            end
            c++;
            if (c >= w) begin
                c = 0;
                fill_slot = (fill_slot + 1) % 3;
                r++;
                if (r >= h) r = 0;
            end
            col_pos = c;
            row_pos = r;
            pixels_seen++;
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_thinned(logic [COL_W-1:0] column, logic [ROW_W-1:0] row,
                                    mag_t kept, phase_t phase, logic last);
            thinned_t e;
            results_seen++;
            if (due.size() == 0) begin
                $error("result for column %0d row %0d arrived with none expected",
                       column, row);
                mismatches++;
                return;
            end
            e = due.pop_front();
            compare_field("column", e.column, column);
            compare_field("row", e.row, row);
            compare_field("kept_magnitude", e.kept, kept);
            compare_field("phase_out", e.phase, phase);
            compare_field("last", e.last, last);
        endfunction
    endclass

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = '0;
    logic [CFG_W-1:0]           cfg_wr_data = '0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic [MAG_W-1:0]           s_magnitude = '0;
    logic signed [PHASE_W-1:0]  s_phase     = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic [COL_W-1:0]           m_column;
    logic [ROW_W-1:0]           m_row;
    logic [MAG_W-1:0]           m_kept_magnitude;
    logic signed [PHASE_W-1:0]  m_phase_out;
    logic                       m_last;

    // While set, neither side idles, so the unit runs at its full rate for a
    // long stretch of the random part.
    bit                         steady = 1'b0;
    int unsigned                settings = 0;
    thinned_pixel_board         board;

    gradient_non_max_suppression_unit #(
        .MAX_WIDTH(MAX_W)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_magnitude      (s_magnitude),
        .s_phase          (s_phase),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_column         (m_column),
        .m_row            (m_row),
        .m_kept_magnitude (m_kept_magnitude),
        .m_phase_out      (m_phase_out),
        .m_last           (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Unless steady is set, the result side stalls in roughly nine percent of cycles.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 9);
    end

    // All handshakes are observed here, at the clock edge where they complete,
    // so register writes, taken items and results reach the board in order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) board.write_reg(cfg_index, cfg_wr_data);
            if (s_valid && s_ready) board.note_pixel(s_magnitude, s_phase);
            if (m_valid && m_ready) begin
                board.check_thinned(m_column, m_row, m_kept_magnitude, m_phase_out, m_last);
            end
        end
    end

    // Magnitudes lean towards small values so that ties and near ties between
    // neighbours are common; the rest covers the full range and its extremes.
    function automatic mag_t random_mag();
        case ($urandom_range(3))
            0:       return mag_t'($urandom_range(7));
            1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            2:       return mag_t'(1000 + $urandom_range(2));
            default: return mag_t'($urandom);
        endcase
    endfunction

    // Phases mostly span [-pi, pi], with a share placed right at the direction
    // boundaries and a share anywhere in the field, beyond pi included.
    function automatic phase_t random_phase();
        int bounds[4] = '{PI_8, PI3_8, PI5_8, PI7_8};
        int near_bound;
        case ($urandom_range(9))
            0: return phase_t'($urandom);
            1, 2: begin
                near_bound = bounds[$urandom_range(3)] + int'($urandom_range(2)) - 1;
                return phase_t'($urandom_range(1) ? near_bound : -near_bound);
            end
            default: return phase_t'(int'($urandom_range(2 * PHASE_SPAN)) - PHASE_SPAN);
        endcase
    endfunction

    // Offer one pixel and hold it until the unit takes it. Now and then the
    // valid line drops for a cycle first.
    task automatic send_pixel(input mag_t mag, input phase_t phase);
        if (!steady && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_magnitude <= mag;
        s_phase     <= phase;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Program a new frame size once the unit has gone quiet. Writing either
    // register restarts the frame at the top left corner.
    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        s_valid <= 1'b0;
        // Waiting for an edge lets the board record the item taken just before.
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (HOLD_OFF) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_IMAGE_WIDTH;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_index   <= REG_IMAGE_HEIGHT;
        cfg_wr_data <= h;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        settings++;
    endtask

    initial begin
        int          sweep[21];
        int unsigned random_sent;
        int unsigned w_pick;
        int unsigned h_pick;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned frame_px;
        int unsigned count;
        int unsigned drain;

        board = new();
        // Phases on and just beside every direction boundary, in both signs,
        // then pi and the two ends of the field.
        sweep = '{0, PI_8, PI_8 + 1, -PI_8, -PI_8 - 1,
                  PI3_8 - 1, PI3_8, -(PI3_8 - 1), -PI3_8,
                  PI5_8, PI5_8 + 1, -PI5_8, -PI5_8 - 1,
                  PI7_8 - 1, PI7_8, -(PI7_8 - 1), -PI7_8,
                  PHASE_SPAN, -PHASE_SPAN, 16383, -16384};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: a narrow, tall frame walks the boundary phases with
        // extreme and equal magnitudes, so every direction meets the clamped
        // edges and the last row. Then width 0 and height 1, both of which
        // saturate to two.
        set_frame(12'd3, 12'd7);
        for (int i = 0; i < 21; i++) begin
            send_pixel((i % 4 == 0) ? 16'hFFFF : (i % 4 == 1) ? 16'h0000 : 16'h8000,
                       phase_t'(sweep[i]));
        end
        set_frame(12'd0, 12'd1);
        repeat (4) send_pixel(random_mag(), random_phase());

        // Random part: small frames of random size. Most runs are whole frames,
        // some wrapping into the next frame; the rest stop part way so that the
        // next register write restarts a frame in progress.
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            w_pick = ($urandom_range(7) == 0) ? $urandom_range(1) : $urandom_range(7, 2);
            h_pick = ($urandom_range(7) == 0) ? $urandom_range(1) : $urandom_range(5, 2);
            w_eff = (w_pick < 2) ? 2 : w_pick;
            h_eff = (h_pick < 2) ? 2 : h_pick;
            frame_px = w_eff * h_eff;
            if ($urandom_range(3) == 0) begin
                count = $urandom_range(frame_px, 1);
            end else begin
                count = frame_px * $urandom_range(2, 1) + $urandom_range(2);
            end
            set_frame(w_pick[CFG_W-1:0], h_pick[CFG_W-1:0]);
            repeat (count) begin
                steady = (random_sent >= 40 && random_sent < 90);
                send_pixel(random_mag(), random_phase());
                random_sent++;
            end
        end
        steady = 1'b0;

        // Widest setting: 4095 saturates to the line store size and height 0
        // to two rows. Only the start of the first row is sent, which
        // releases nothing.
        set_frame(12'd4095, 12'd0);
        repeat (12) send_pixel(random_mag(), random_phase());

        // Tallest setting: only the first rows are sent, the frame is never
        // finished.
        set_frame(12'd2, 12'd4095);
        repeat (14) send_pixel(random_mag(), random_phase());

        s_valid <= 1'b0;
        @(posedge aclk);
        drain = 0;
        while (board.pending() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        if (board.pending() != 0) begin
            $error("%0d expected results never arrived", board.pending());
            board.mismatches += board.pending();
        end
        repeat (HOLD_OFF) @(posedge aclk);

        $display("Sent %0d pixels and checked %0d thinned results over %0d frame sizes,",
                 board.pixels_seen, board.results_seen, settings);
        $display("from saturated 0 and 1 up to 4095, with phases across every boundary.");
        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: gradient_non_max_suppression_unit.f
rtl/gnms_pkg.sv
rtl/gnms_front.sv
rtl/gnms_queue.sv
rtl/gnms_back.sv
rtl/gradient_non_max_suppression_unit.sv
sim/gradient_non_max_suppression_unit_test.sv
